### rtl/bfs_pkg.sv
`timescale 1ns / 1ps
package bfs_pkg;

  // Breadcrumb ring geometry
  localparam int RING_DEPTH = 256;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int CNT_W      = $clog2(RING_DEPTH + 1);
  localparam int SUM_W      = RING_AW + 1;

  // Arithmetic widths
  localparam int POS_W   = 20;
  localparam int DIFF_W  = 21;
  localparam int SQ_W    = 42;
  localparam int MUL_W   = 24;
  localparam int PROD_W  = 48;
  localparam int CORD_W  = 40;
  localparam int ANG_W   = 24;
  localparam int ROOT_W  = 21;
  localparam int CORD_STEPS = 18;
  localparam int SQRT_STEPS = 21;
  localparam int STEP_W  = 5;

  // Configuration register indexes
  localparam logic [2:0] REG_NEAR       = 3'd0;
  localparam logic [2:0] REG_FAR        = 3'd1;
  localparam logic [2:0] REG_GAP        = 3'd2;
  localparam logic [2:0] REG_SPEED_GAIN = 3'd3;
  localparam logic [2:0] REG_SPEED_FLR  = 3'd4;
  localparam logic [2:0] REG_STEER_GAIN = 3'd5;

  typedef enum logic [3:0] {
    S_IDLE, S_PUSH, S_DY, S_NSQ, S_FSQ, S_SEL, S_GY, S_GSQ,
    S_CINIT, S_ITER, S_STEER, S_SPD, S_FIN, S_OUT
  } state_e;

  // Arctangent of 2^-i in units of 2^-24 turn
  function automatic logic [ANG_W-1:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic [ANG_W-1:0] v;
    case (idx)
      5'd0:  v = 24'd2097152;
      5'd1:  v = 24'd1238021;
      5'd2:  v = 24'd654136;
      5'd3:  v = 24'd332050;
      5'd4:  v = 24'd166669;
      5'd5:  v = 24'd83416;
      5'd6:  v = 24'd41718;
      5'd7:  v = 24'd20860;
      5'd8:  v = 24'd10430;
      5'd9:  v = 24'd5215;
      5'd10: v = 24'd2608;
      5'd11: v = 24'd1304;
      5'd12: v = 24'd652;
      5'd13: v = 24'd326;
      5'd14: v = 24'd163;
      5'd15: v = 24'd81;
      5'd16: v = 24'd41;
      5'd17: v = 24'd20;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/bfs_iter.sv
`timescale 1ns / 1ps
// Iterative bearing (vectoring CORDIC) and integer square root, one step per cycle
module bfs_iter (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [bfs_pkg::DIFF_W-1:0]  dx_i,
  input  logic signed [bfs_pkg::DIFF_W-1:0]  dy_i,
  input  logic        [bfs_pkg::SQ_W-1:0]    sq_i,
  output logic                               done_o,
  output logic        [15:0]                 bearing_o,
  output logic        [bfs_pkg::ROOT_W-1:0]  root_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [bfs_pkg::STEP_W-1:0]         cnt_q, cnt_d;
  logic signed [bfs_pkg::CORD_W-1:0]  x_q, x_d, y_q, y_d, xs, ys, xi, yi;
  logic [bfs_pkg::ANG_W-1:0]          z_q, z_d, z_rnd;
  logic                               zero_q, zero_d;
  logic [bfs_pkg::SQ_W-1:0]           rem_q, rem_d, res_q, res_d, bit_q, bit_d, trial;

  assign xi    = {{3{dx_i[bfs_pkg::DIFF_W-1]}}, dx_i, 16'b0};
  assign yi    = {{3{dy_i[bfs_pkg::DIFF_W-1]}}, dy_i, 16'b0};
  assign xs    = x_q >>> cnt_q;
  assign ys    = y_q >>> cnt_q;
  assign trial = res_q + bit_q;

  // Step both iterations
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    zero_d = zero_q;
    rem_d  = rem_q;
    res_d  = res_q;
    bit_d  = bit_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      zero_d = (dx_i == '0) && (dy_i == '0);
      if (dx_i[bfs_pkg::DIFF_W-1]) begin
        x_d = -xi;
        y_d = -yi;
        z_d = 24'h800000;
      end else begin
        x_d = xi;
        y_d = yi;
        z_d = '0;
      end
      rem_d = sq_i;
      res_d = '0;
      bit_d = bfs_pkg::SQ_W'(1) << (2 * (bfs_pkg::SQRT_STEPS - 1));
    end else if (busy_q) begin
      if (cnt_q < bfs_pkg::STEP_W'(bfs_pkg::CORD_STEPS)) begin
        if (!y_q[bfs_pkg::CORD_W-1]) begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + bfs_pkg::atan_lut(cnt_q);
        end else begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - bfs_pkg::atan_lut(cnt_q);
        end
      end
      if (rem_q >= trial) begin
        rem_d = rem_q - trial;
        res_d = (res_q >> 1) + bit_q;
      end else begin
        res_d = res_q >> 1;
      end
      bit_d = bit_q >> 2;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == bfs_pkg::STEP_W'(bfs_pkg::SQRT_STEPS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    zero_q <= zero_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
  end

  // Round to 2^-16 turn
  assign z_rnd     = z_q + 24'd128;
  assign bearing_o = zero_q ? 16'd0 : z_rnd[23:8];
  assign root_o    = res_q[bfs_pkg::ROOT_W-1:0];
  assign done_o    = done_q;

endmodule

### rtl/breadcrumb_follow_steering_top.sv
`timescale 1ns / 1ps
// Breadcrumb follower for one lane, one transaction per control tick. Each input
// transaction pushes the predecessor onto a 256-entry ring, picks the target
// (pop on near, clear on far) and returns speed, steering, the new target and
// two status flags. Each item runs through the 21-step square root / 18-step
// CORDIC unit and one shared 24x24 multiplier used for nine products; a new
// input is taken only after the previous result has been taken. The ring needs no
// clearing after reset.
module breadcrumb_follow_steering_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // pred_x[19:0], pred_y[39:20], self_x[59:40], self_y[79:60], self_yaw[95:80]
  input  logic [95:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // speed_cmd[15:0], steer_cmd[31:16], aim_x[51:32], aim_y[71:52]
  output logic [71:0] m_axis_tdata,
  // trail_reset[0], trail_overflow[1]
  output logic [1:0]  m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = bfs_pkg::RING_AW;
  localparam int PW = bfs_pkg::POS_W;

  bfs_pkg::state_e state_q, state_d;

  // Configuration
  logic [15:0] near_q, gap_q, sgain_q, sfloor_q, stgain_q;
  logic [19:0] far_q;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_q   <= 16'd205;
      far_q    <= 20'd5120;
      gap_q    <= 16'd410;
      sgain_q  <= 16'd19661;
      sfloor_q <= 16'd51;
      stgain_q <= 16'd256;
    end else if (cfg_wr) begin
      case (reg_idx)
        bfs_pkg::REG_NEAR:       near_q   <= pwdata[15:0];
        bfs_pkg::REG_FAR:        far_q    <= pwdata[19:0];
        bfs_pkg::REG_GAP:        gap_q    <= pwdata[15:0];
        bfs_pkg::REG_SPEED_GAIN: sgain_q  <= pwdata[15:0];
        bfs_pkg::REG_SPEED_FLR:  sfloor_q <= pwdata[15:0];
        bfs_pkg::REG_STEER_GAIN: stgain_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      bfs_pkg::REG_NEAR:       prdata = {16'b0, near_q};
      bfs_pkg::REG_FAR:        prdata = {12'b0, far_q};
      bfs_pkg::REG_GAP:        prdata = {16'b0, gap_q};
      bfs_pkg::REG_SPEED_GAIN: prdata = {16'b0, sgain_q};
      bfs_pkg::REG_SPEED_FLR:  prdata = {16'b0, sfloor_q};
      bfs_pkg::REG_STEER_GAIN: prdata = {16'b0, stgain_q};
      default:                 prdata = '0;
    endcase
  end

  // Datapath registers
  logic signed [PW-1:0] px_q, py_q, sx_q, sy_q, tx_q, ty_q;
  logic [15:0]          yaw_q;
  logic [AW-1:0]        head_q;
  logic [bfs_pkg::CNT_W-1:0] count_q;
  logic                 ovf_q, rst_q;
  logic [bfs_pkg::SQ_W-1:0] acc_q, d2_q, g2_q;
  logic [31:0]          nsq_q, gsq_q;
  logic signed [bfs_pkg::PROD_W-1:0] prod_q;
  logic [2*PW-1:0]      rd_q;
  logic signed [15:0]   steer_q;
  logic [71:0]          out_data_q;
  logic [1:0]           out_user_q;
  logic [2*PW-1:0]      ring_mem [bfs_pkg::RING_DEPTH];

  logic accept, take, near_hit, far_hit;
  logic [AW-1:0]  head_inc, slot;
  logic [bfs_pkg::SUM_W-1:0] slot_sum;
  logic signed [bfs_pkg::DIFF_W-1:0] dtx, dty, dgx, dgy;
  logic signed [bfs_pkg::MUL_W-1:0] mul_a, mul_b;
  logic signed [bfs_pkg::PROD_W-1:0] steer_rnd, steer_sh;
  logic [bfs_pkg::PROD_W-1:0] spd_rnd;
  logic [15:0] err;
  logic [15:0] bearing;
  logic [bfs_pkg::ROOT_W-1:0] root;
  logic iter_start, iter_done;
  logic [15:0] speed;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign take   = m_axis_tvalid && m_axis_tready;

  assign head_inc = (head_q == AW'(bfs_pkg::RING_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign slot_sum = bfs_pkg::SUM_W'(head_q) + bfs_pkg::SUM_W'(count_q);
  assign slot     = (slot_sum >= bfs_pkg::SUM_W'(bfs_pkg::RING_DEPTH))
                  ? AW'(slot_sum - bfs_pkg::SUM_W'(bfs_pkg::RING_DEPTH))
                  : AW'(slot_sum);

  assign dtx = bfs_pkg::DIFF_W'(tx_q) - bfs_pkg::DIFF_W'(sx_q);
  assign dty = bfs_pkg::DIFF_W'(ty_q) - bfs_pkg::DIFF_W'(sy_q);
  assign dgx = bfs_pkg::DIFF_W'(px_q) - bfs_pkg::DIFF_W'(sx_q);
  assign dgy = bfs_pkg::DIFF_W'(py_q) - bfs_pkg::DIFF_W'(sy_q);

  assign near_hit = d2_q < bfs_pkg::SQ_W'(nsq_q);
  assign far_hit  = d2_q > bfs_pkg::SQ_W'(prod_q[39:0]);
  assign err      = bearing - yaw_q;

  assign steer_rnd = prod_q + 48'sd128;
  assign steer_sh  = steer_rnd >>> 8;
  assign spd_rnd   = prod_q + 48'd32768;

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bfs_pkg::S_IDLE:  if (accept) state_d = bfs_pkg::S_PUSH;
      bfs_pkg::S_PUSH:  state_d = bfs_pkg::S_DY;
      bfs_pkg::S_DY:    state_d = bfs_pkg::S_NSQ;
      bfs_pkg::S_NSQ:   state_d = bfs_pkg::S_FSQ;
      bfs_pkg::S_FSQ:   state_d = bfs_pkg::S_SEL;
      bfs_pkg::S_SEL:   state_d = bfs_pkg::S_GY;
      bfs_pkg::S_GY:    state_d = bfs_pkg::S_GSQ;
      bfs_pkg::S_GSQ:   state_d = bfs_pkg::S_CINIT;
      bfs_pkg::S_CINIT: state_d = bfs_pkg::S_ITER;
      bfs_pkg::S_ITER:  if (iter_done) state_d = bfs_pkg::S_STEER;
      bfs_pkg::S_STEER: state_d = bfs_pkg::S_SPD;
      bfs_pkg::S_SPD:   state_d = bfs_pkg::S_FIN;
      bfs_pkg::S_FIN:   state_d = bfs_pkg::S_OUT;
      bfs_pkg::S_OUT:   if (take) state_d = bfs_pkg::S_IDLE;
      default:          state_d = bfs_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs: handshakes and multiplier operands
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    iter_start    = 1'b0;
    mul_a         = '0;
    mul_b         = '0;
    case (state_q)
      bfs_pkg::S_IDLE:  s_axis_tready = 1'b1;
      bfs_pkg::S_PUSH:  begin mul_a = bfs_pkg::MUL_W'(dtx); mul_b = bfs_pkg::MUL_W'(dtx); end
      bfs_pkg::S_DY:    begin mul_a = bfs_pkg::MUL_W'(dty); mul_b = bfs_pkg::MUL_W'(dty); end
      bfs_pkg::S_NSQ:   begin mul_a = {8'b0, near_q}; mul_b = {8'b0, near_q}; end
      bfs_pkg::S_FSQ:   begin mul_a = {4'b0, far_q}; mul_b = {4'b0, far_q}; end
      bfs_pkg::S_SEL:   begin mul_a = bfs_pkg::MUL_W'(dgx); mul_b = bfs_pkg::MUL_W'(dgx); end
      bfs_pkg::S_GY:    begin mul_a = bfs_pkg::MUL_W'(dgy); mul_b = bfs_pkg::MUL_W'(dgy); end
      bfs_pkg::S_GSQ:   begin mul_a = {8'b0, gap_q}; mul_b = {8'b0, gap_q}; end
      bfs_pkg::S_CINIT: iter_start = 1'b1;
      bfs_pkg::S_STEER: begin
        mul_a = {8'b0, stgain_q};
        mul_b = bfs_pkg::MUL_W'($signed(err));
      end
      bfs_pkg::S_SPD:   begin mul_a = {8'b0, sgain_q}; mul_b = {3'b0, root}; end
      bfs_pkg::S_OUT:   m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfs_pkg::S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      tx_q    <= '0;
      ty_q    <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        bfs_pkg::S_IDLE: begin
          // make room when the ring is full
          if (accept && count_q == bfs_pkg::CNT_W'(bfs_pkg::RING_DEPTH)) begin
            head_q  <= head_inc;
            count_q <= bfs_pkg::CNT_W'(bfs_pkg::RING_DEPTH - 1);
          end
        end
        bfs_pkg::S_PUSH: count_q <= count_q + 1'b1;
        bfs_pkg::S_SEL: begin
          if (near_hit) begin
            tx_q    <= rd_q[PW-1:0];
            ty_q    <= rd_q[2*PW-1:PW];
            head_q  <= head_inc;
            count_q <= count_q - 1'b1;
          end else if (far_hit) begin
            head_q  <= '0;
            count_q <= '0;
            tx_q    <= px_q;
            ty_q    <= py_q;
          end else if (tx_q == '0 && ty_q == '0) begin
            tx_q <= px_q;
            ty_q <= py_q;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      bfs_pkg::S_IDLE: begin
        if (accept) begin
          px_q  <= s_axis_tdata[19:0];
          py_q  <= s_axis_tdata[39:20];
          sx_q  <= s_axis_tdata[59:40];
          sy_q  <= s_axis_tdata[79:60];
          yaw_q <= s_axis_tdata[95:80];
          ovf_q <= (count_q == bfs_pkg::CNT_W'(bfs_pkg::RING_DEPTH));
          rst_q <= 1'b0;
        end
      end
      bfs_pkg::S_DY:    acc_q <= prod_q[bfs_pkg::SQ_W-1:0];
      bfs_pkg::S_NSQ:   d2_q  <= acc_q + prod_q[bfs_pkg::SQ_W-1:0];
      bfs_pkg::S_FSQ:   nsq_q <= prod_q[31:0];
      bfs_pkg::S_SEL:   rst_q <= !near_hit && far_hit;
      bfs_pkg::S_GY:    acc_q <= prod_q[bfs_pkg::SQ_W-1:0];
      bfs_pkg::S_GSQ:   g2_q  <= acc_q + prod_q[bfs_pkg::SQ_W-1:0];
      bfs_pkg::S_CINIT: gsq_q <= prod_q[31:0];
      bfs_pkg::S_SPD: begin
        // saturate the rounded steering product
        if (steer_sh > 48'sd32767)       steer_q <= 16'sh7fff;
        else if (steer_sh < -48'sd32768) steer_q <= 16'sh8000;
        else                             steer_q <= steer_sh[15:0];
      end
      bfs_pkg::S_FIN: begin
        out_data_q <= {ty_q, tx_q, steer_q, speed};
        out_user_q <= {ovf_q, rst_q};
      end
      default: ;
    endcase
  end

  assign speed = (g2_q > bfs_pkg::SQ_W'(gsq_q))
               ? ((spd_rnd[47:32] != '0) ? 16'hffff : spd_rnd[31:16])
               : sfloor_q;

  // Breadcrumb ring
  always_ff @(posedge clk_i) begin
    if (state_q == bfs_pkg::S_PUSH) ring_mem[slot] <= {py_q, px_q};
    if (state_q == bfs_pkg::S_DY)   rd_q <= ring_mem[head_q];
  end

  bfs_iter u_iter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (iter_start),
    .dx_i      (dtx),
    .dy_i      (dty),
    .sq_i      (g2_q),
    .done_o    (iter_done),
    .bearing_o (bearing),
    .root_o    (root)
  );

  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_user_q;

endmodule

### tb/sv/breadcrumb_follow_steering_top_test.sv
`timescale 1ns / 1ps
module breadcrumb_follow_steering_top_test;

  localparam int CRUMBS = 256;
  localparam logic [2:0] REG_UNUSED = 3'd6;
  localparam longint POS_MAX = 524287;
  localparam longint POS_MIN = -524288;

  typedef struct {
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic signed [19:0] sx;
    logic signed [19:0] sy;
    logic [15:0]        yaw;
  } tick_t;

  typedef struct {
    logic [15:0]        speed;
    logic signed [15:0] steer;
    logic signed [19:0] aim_x;
    logic signed [19:0] aim_y;
    logic               trail_rst;
    logic               trail_ovf;
  } cmd_t;

  typedef struct {
    tick_t t;
    bit    typed;
    cmd_t  c;
  } row_t;

  typedef enum int { GO_HOLD, GO_NEAR, GO_FAR, GO_NOISE } walk_e;

  // Arctangent of 2^-i, 2^-24 turn
  localparam logic [31:0] ATAN_24 [18] = '{
    32'd2097152, 32'd1238021, 32'd654136, 32'd332050, 32'd166669, 32'd83416,
    32'd41718, 32'd20860, 32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652,
    32'd326, 32'd163, 32'd81, 32'd41, 32'd20
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  breadcrumb_follow_steering_top uut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Follower state mirror
  longint     near_thr, far_thr, gap_thr, spd_gain, spd_floor, str_gain;
  logic [39:0] crumbs [CRUMBS];
  int         head, count;
  longint     aim_x, aim_y;
  longint     walk_x, walk_y;
  cmd_t       pending_cmds[$];
  int         fails = 0;
  bit         quiet_src = 0, quiet_sink = 0;
  int         stall_left = 0;

  function automatic logic [15:0] bearing_of(longint dx, longint dy);
    longint x, y, xs, ys;
    logic [31:0] z;
    if (dx == 0 && dy == 0) return 16'd0;
    x = dx * 65536;
    y = dy * 65536;
    z = 0;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = 32'h800000;
    end
    for (int i = 0; i < 18; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys;
        y -= xs;
        z += ATAN_24[i];
      end else begin
        x -= ys;
        y += xs;
        z -= ATAN_24[i];
      end
    end
    z = (z + 32'd128) >> 8;
    return z[15:0];
  endfunction

  function automatic longint root_of(longint v);
    longint r, t;
    r = 0;
    for (int b = 23; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Advance the mirror by one control tick and return the commands it gives
  function automatic cmd_t follow_tick(tick_t t);
    cmd_t   c;
    longint px, py, sx, sy, d2, g2, prod, st, spd;
    logic [15:0] err;
    logic [39:0] e;
    px = t.px; py = t.py; sx = t.sx; sy = t.sy;
    c.trail_rst = 1'b0;
    c.trail_ovf = 1'b0;
    if (count >= CRUMBS) begin
      head = (head + 1) % CRUMBS;
      count = CRUMBS - 1;
      c.trail_ovf = 1'b1;
    end
    crumbs[(head + count) % CRUMBS] = {t.py, t.px};
    count++;
    d2 = (aim_x - sx) * (aim_x - sx) + (aim_y - sy) * (aim_y - sy);
    if (aim_x == 0 && aim_y == 0) begin
      aim_x = px;
      aim_y = py;
    end
    if (d2 < near_thr * near_thr) begin
      e = crumbs[head];
      aim_x = longint'(signed'(e[19:0]));
      aim_y = longint'(signed'(e[39:20]));
      head = (head + 1) % CRUMBS;
      count--;
    end else if (d2 > far_thr * far_thr) begin
      head = 0;
      count = 0;
      aim_x = px;
      aim_y = py;
      c.trail_rst = 1'b1;
    end
    err = bearing_of(aim_x - sx, aim_y - sy) - t.yaw;
    prod = str_gain * longint'(signed'(err));
    st = (prod + 128) >>> 8;
    if (st > 32767) st = 32767;
    if (st < -32768) st = -32768;
    g2 = (px - sx) * (px - sx) + (py - sy) * (py - sy);
    if (g2 > gap_thr * gap_thr) begin
      spd = (spd_gain * root_of(g2) + 32768) >> 16;
      if (spd > 65535) spd = 65535;
    end else begin
      spd = spd_floor;
    end
    c.speed = spd[15:0];
    c.steer = st[15:0];
    c.aim_x = aim_x[19:0];
    c.aim_y = aim_y[19:0];
    return c;
  endfunction

  function automatic int pick_gap();
    int k;
    if (quiet_src) return 0;
    k = $urandom_range(0, 99);
    if (k < 60) return 0;
    if (k < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one tick, hold it until taken, then log the expected commands
  task automatic send_tick(row_t r);
    int   gap;
    cmd_t c;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata <= {r.t.yaw, r.t.sy, r.t.sx, r.t.py, r.t.px};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    c = follow_tick(r.t);
    pending_cmds.push_back(r.typed ? r.c : c);
  endtask

  // Drain all results, then let the block settle
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      bfs_pkg::REG_NEAR:       near_thr = val[15:0];
      bfs_pkg::REG_FAR:        far_thr = val[19:0];
      bfs_pkg::REG_GAP:        gap_thr = val[15:0];
      bfs_pkg::REG_SPEED_GAIN: spd_gain = val[15:0];
      bfs_pkg::REG_SPEED_FLR:  spd_floor = val[15:0];
      bfs_pkg::REG_STEER_GAIN: str_gain = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_all(longint n, longint f, longint g, longint sg, longint sf,
                         longint kg);
    // Upper junk bits must be dropped by the register width
    reg_write(bfs_pkg::REG_NEAR, 32'({$urandom_range(0, 65535), 16'h0} | n));
    reg_write(bfs_pkg::REG_FAR, 32'({$urandom_range(0, 4095), 20'h0} | f));
    reg_write(bfs_pkg::REG_GAP, 32'({$urandom_range(0, 65535), 16'h0} | g));
    reg_write(bfs_pkg::REG_SPEED_GAIN, 32'({$urandom_range(0, 65535), 16'h0} | sg));
    reg_write(bfs_pkg::REG_SPEED_FLR, 32'({$urandom_range(0, 65535), 16'h0} | sf));
    reg_write(bfs_pkg::REG_STEER_GAIN, 32'({$urandom_range(0, 65535), 16'h0} | kg));
  endtask

  function automatic longint rand_pos();
    return longint'(signed'(20'($urandom_range(0, 20'hFFFFF))));
  endfunction

  function automatic longint step_clamp(longint v, longint d);
    if (v + d > POS_MAX || v + d < POS_MIN) return v - d;
    return v + d;
  endfunction

  // Build one tick that steers the target logic into the wanted branch
  function automatic row_t make_tick(walk_e w);
    row_t   r;
    longint lo, hi, rad, ox, oy;
    if ($urandom_range(0, 19) == 0) begin
      walk_x = rand_pos();
      walk_y = rand_pos();
    end else begin
      walk_x = step_clamp(walk_x, longint'($urandom_range(0, 4000)) - 2000);
      walk_y = step_clamp(walk_y, longint'($urandom_range(0, 4000)) - 2000);
    end
    if (w == GO_NEAR && near_thr == 0) w = GO_FAR;
    if (w == GO_HOLD && near_thr > far_thr) w = GO_FAR;
    case (w)
      GO_HOLD: begin
        lo = near_thr;
        hi = (far_thr > 200000) ? 200000 : far_thr;
        if (hi < lo) hi = lo;
        rad = lo + longint'($urandom_range(0, 32'(hi - lo)));
      end
      GO_NEAR: begin
        hi = (near_thr - 1 > 200000) ? 200000 : near_thr - 1;
        rad = longint'($urandom_range(0, 32'(hi)));
      end
      default: rad = 0;
    endcase
    ox = ($urandom_range(0, 1) != 0) ? rad : -rad;
    oy = 0;
    if ($urandom_range(0, 1) != 0) begin
      oy = ox;
      ox = 0;
    end
    r.t.px = walk_x[19:0];
    r.t.py = walk_y[19:0];
    r.t.yaw = 16'($urandom_range(0, 65535));
    r.typed = 0;
    if (w == GO_HOLD || w == GO_NEAR) begin
      r.t.sx = 20'(step_clamp(aim_x, ox));
      r.t.sy = 20'(step_clamp(aim_y, oy));
    end else if (w == GO_FAR) begin
      r.t.sx = 20'(rand_pos());
      r.t.sy = 20'(rand_pos());
    end else begin
      r.t.px = 20'(rand_pos());
      r.t.py = 20'(rand_pos());
      r.t.sx = 20'(rand_pos());
      r.t.sy = 20'(rand_pos());
    end
    return r;
  endfunction

  function automatic walk_e pick_walk(int hold_pct);
    int k;
    k = $urandom_range(0, 99);
    if (k < hold_pct) return GO_HOLD;
    if (k < hold_pct + (100 - hold_pct) / 2) return GO_NEAR;
    if (k < 95) return GO_FAR;
    return GO_NOISE;
  endfunction

  // Sink: random back-pressure with occasional long stalls
  always @(posedge clk_i) begin
    if (quiet_sink) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 4) begin
      stall_left <= $urandom_range(10, 60);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) < 75);
    end
  end

  // Check each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    cmd_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_cmds.size() == 0) begin
        $error("unexpected result transaction");
        fails++;
      end else begin
        want = pending_cmds.pop_front();
        if (m_axis_tdata[15:0] !== want.speed) begin
          $error("speed_cmd: expected %0d, got %0d", want.speed, m_axis_tdata[15:0]);
          fails++;
        end
        if (m_axis_tdata[31:16] !== want.steer) begin
          $error("steer_cmd: expected %0d, got %0d", want.steer,
                 $signed(m_axis_tdata[31:16]));
          fails++;
        end
        if (m_axis_tdata[51:32] !== want.aim_x) begin
          $error("aim_x: expected %0d, got %0d", want.aim_x, $signed(m_axis_tdata[51:32]));
          fails++;
        end
        if (m_axis_tdata[71:52] !== want.aim_y) begin
          $error("aim_y: expected %0d, got %0d", want.aim_y, $signed(m_axis_tdata[71:52]));
          fails++;
        end
        if (m_axis_tuser[0] !== want.trail_rst) begin
          $error("trail_reset: expected %0b, got %0b", want.trail_rst, m_axis_tuser[0]);
          fails++;
        end
        if (m_axis_tuser[1] !== want.trail_ovf) begin
          $error("trail_overflow: expected %0b, got %0b", want.trail_ovf, m_axis_tuser[1]);
          fails++;
        end
      end
    end
  end

  initial begin
    #4ms;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    row_t rows[$];
    row_t r;
    int   hold_pct;
    near_thr = 205; far_thr = 5120; gap_thr = 410;
    spd_gain = 19661; spd_floor = 51; str_gain = 256;
    head = 0; count = 0; aim_x = 0; aim_y = 0;
    walk_x = 0; walk_y = 0;
    foreach (crumbs[i]) crumbs[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset defaults, first tick, far clear, extremes, half-turn error
    r.typed = 1;
    r.t = '{px: 20'sd1000, py: 20'sd0, sx: 20'sd0, sy: 20'sd0, yaw: 16'd0};
    r.c = '{speed: 16'd300, steer: 16'sd0, aim_x: 20'sd1000, aim_y: 20'sd0,
            trail_rst: 1'b0, trail_ovf: 1'b0};
    rows.push_back(r);
    r.typed = 0;
    r.t = '{px: 20'sh7FFFF, py: 20'sh7FFFF, sx: 20'sh80000, sy: 20'sh80000, yaw: 16'hFFFF};
    rows.push_back(r);
    r.typed = 1;
    r.t = '{px: 20'sh7FFFF, py: 20'sh7FFFF, sx: 20'sh7FFFF, sy: 20'sh7FFFF, yaw: 16'h8000};
    r.c = '{speed: 16'd51, steer: 16'sh8000, aim_x: 20'sh7FFFF, aim_y: 20'sh7FFFF,
            trail_rst: 1'b0, trail_ovf: 1'b0};
    rows.push_back(r);
    r.typed = 0;
    r.t = '{px: 20'sh80000, py: 20'sh7FFFF, sx: 20'sh7FFFF, sy: 20'sh80000, yaw: 16'h0000};
    rows.push_back(r);
    r.t = '{px: 20'sh80000, py: 20'sh80000, sx: 20'sh80000, sy: 20'sh80000, yaw: 16'h4000};
    rows.push_back(r);
    r.t = '{px: -20'sd500, py: 20'sd0, sx: 20'sd0, sy: 20'sd0, yaw: 16'h7FFF};
    rows.push_back(r);
    r.t = '{px: 20'sd0, py: -20'sd500, sx: 20'sd0, sy: 20'sd0, yaw: 16'hC000};
    rows.push_back(r);
    r.t = '{px: 20'sd300, py: 20'sd300, sx: 20'sd0, sy: 20'sd0, yaw: 16'h2000};
    rows.push_back(r);
    foreach (rows[i]) send_tick(rows[i]);
    rows.delete();
    for (int i = 0; i < 14; i++) begin
      r = make_tick(walk_e'(i % 4));
      send_tick(r);
    end

    // Extreme settings: all maximum to saturate steering and speed, then all zero
    wait_idle();
    set_all(65535, 1048575, 65535, 65535, 65535, 65535);
    for (int i = 0; i < 60; i++) send_tick(make_tick(pick_walk(40)));
    wait_idle();
    set_all(0, 0, 0, 0, 0, 0);
    for (int i = 0; i < 60; i++) send_tick(make_tick(pick_walk(40)));

    // Long hold run overfills the ring; no idling in this stretch
    wait_idle();
    set_all(205, 5120, 410, 19661, 51, 256);
    quiet_src = 1;
    quiet_sink = 1;
    for (int i = 0; i < 300; i++) send_tick(make_tick(GO_HOLD));
    quiet_src = 0;
    quiet_sink = 0;
    for (int i = 0; i < 40; i++) send_tick(make_tick(pick_walk(50)));

    // Random settings, mostly well-formed target walks
    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      reg_write(REG_UNUSED, $urandom());
      set_all($urandom_range(0, 3000), $urandom_range(2000, 80000),
              $urandom_range(0, 3000), $urandom_range(0, 65535),
              $urandom_range(0, 65535), $urandom_range(0, 1024));
      hold_pct = $urandom_range(40, 85);
      for (int i = 0; i < 90; i++) send_tick(make_tick(pick_walk(hold_pct)));
    end

    wait_idle();
    if (pending_cmds.size() != 0) fails++;
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/bfs_pkg.sv
rtl/bfs_iter.sv
rtl/breadcrumb_follow_steering_top.sv
tb/sv/breadcrumb_follow_steering_top_test.sv
